/* hdl/priority_event_slot_queue_core_defines.svh */
// Assertion macros for the priority event slot queue.
// Used by the top level only; depends on nothing else.
`ifndef PRIORITY_EVENT_SLOT_QUEUE_CORE_DEFINES_SVH
`define PRIORITY_EVENT_SLOT_QUEUE_CORE_DEFINES_SVH

// Implication checked while out of reset.
`define PESQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pesq: assertion failed");

// Next-cycle implication that is also checked across reset.
`define PESQ_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pesq: assertion failed");

`endif

/* hdl/pesq_pkg.sv */
// Shared types and constants for the priority event slot queue.
// Depends on nothing; imported by every module of the block.
package pesq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam logic [15:0] BCAST_RESET = 16'hFFFF;

    typedef enum logic {
        ACT_EMIT     = 1'b0,
        ACT_DISPATCH = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_SENT   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Target sits in the lowest bits, payload in the highest.
    typedef struct packed {
        logic [31:0] payload;
        logic [7:0]  etype;
        logic [7:0]  prio;
        logic [15:0] target;
    } t_event;

    typedef struct packed {
        t_action action;
        t_event  ev;
    } t_cmd;

    typedef struct packed {
        logic    broadcast;
        t_status status;
        t_event  ev;
    } t_result;

endpackage

/* hdl/pesq_front.sv */
// Front end of the priority event slot queue: accepts input words, decodes
// the action and holds commands in a two-entry queue. Depends on pesq_pkg.
module pesq_front
    import pesq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    input  logic        i_s_axis_tuser,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.action = t_action'(i_s_axis_tuser);
        w_cmd.ev     = t_event'(i_s_axis_tdata);
    end

    assign o_s_axis_tready = (r_cnt != 2'd2);
    assign o_cmd_valid     = (r_cnt != 2'd0);
    assign o_cmd           = r_buf[r_rp];
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_buf[r_wp] <= w_cmd;
                r_wp        <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/pesq_engine.sv */
// Back end of the priority event slot queue: slot memory, free flags, the
// slot scan for emit and dispatch, and the result register. Depends on pesq_pkg.
module pesq_engine
    import pesq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_bcast,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_res_ready
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_RESULT
    } t_state;

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [CNT_W-1:0]       r_idx;
    logic [QUEUE_DEPTH-1:0] r_free;
    t_event                 r_mem [QUEUE_DEPTH];
    t_event                 r_rd_data;
    logic                   r_rd_vld;
    logic                   r_rd_occ;
    logic [IDX_W-1:0]       r_rd_idx;
    t_event                 r_best;
    logic [IDX_W-1:0]       r_best_idx;
    logic                   r_have;
    t_result                r_res;
    t_result                r_out;
    logic                   r_out_valid;
    logic [IDX_W-1:0]       w_idx;
    logic                   w_wr_en;

    assign w_idx       = r_idx[IDX_W-1:0];
    assign w_wr_en     = (r_state == S_FIND) && r_free[w_idx];
    assign o_cmd_pop   = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_idx] <= r_cmd.ev;
        end
        r_rd_data <= r_mem[w_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '1;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_rd_vld && r_rd_occ && (r_rd_data.prio >= r_best.prio)) begin
                r_best     <= r_rd_data;
                r_best_idx <= r_rd_idx;
                r_have     <= 1'b1;
            end
            if (i_res_ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd       <= i_cmd;
                        r_idx       <= '0;
                        r_have      <= 1'b0;
                        r_best.prio <= '0;
                        r_state     <= (i_cmd.action == ACT_EMIT) ? S_FIND : S_SCAN;
                    end
                end
                S_FIND: begin
                    if (r_free[w_idx]) begin
                        r_free[w_idx] <= 1'b0;
                        r_res         <= '{broadcast: 1'b0, status: ST_STORED, ev: '0};
                        r_state       <= S_RESULT;
                    end else if (r_idx == LAST_IDX) begin
                        r_res   <= '{broadcast: 1'b0, status: ST_FULL, ev: '0};
                        r_state <= S_RESULT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_rd_occ <= ~r_free[w_idx];
                    r_rd_idx <= w_idx;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_LAST;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_LAST: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_have) begin
                        r_free[r_best_idx] <= 1'b1;
                        r_res <= '{broadcast: (r_best.target == i_bcast),
                                   status: ST_SENT, ev: r_best};
                    end else begin
                        r_res <= '{broadcast: 1'b0, status: ST_EMPTY, ev: '0};
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || i_res_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/priority_event_slot_queue_core.sv */
// Priority event slot queue, top level: configuration register, front end,
// back end and checks. Depends on pesq_pkg, pesq_front, pesq_engine and
// priority_event_slot_queue_core_defines.svh.
//
// An input word either emits an event (tuser 0) into the lowest free slot or
// dispatches (tuser 1) the occupied slot of highest priority, the highest
// slot index winning a tie. Every input word gives exactly one output word,
// in order; its tuser carries the status and the broadcast flag.
// The front end queues up to two words, so the input stays ready while the
// back end works or while a result waits to be taken, until two words wait.
// The back end handles one word at a time and walks the slots one per cycle:
// an emit stops at the first free slot, or after the last slot when every
// slot is taken, and a dispatch visits every slot, the slot memory read port
// being visited once per slot.
// If the receiver stalls, the result is held in the output register and the
// back end waits with the next result; input is taken until the queue fills.
// Reset frees every slot, empties both queues and sets the broadcast target
// to all ones. The user must write the broadcast target only while the
// block is idle; the block itself does not enforce this.
module priority_event_slot_queue_core
    import pesq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // target, priority_req, kind, payload
    input  logic [63:0] i_s_axis_tdata,
    // action
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_target, out_priority, out_kind, out_payload
    output logic [63:0] o_m_axis_tdata,
    // status, broadcast
    output logic [2:0]  o_m_axis_tuser
);

`include "priority_event_slot_queue_core_defines.svh"

    logic [15:0] r_bcast;
    logic        w_cmd_valid;
    t_cmd        w_cmd;
    logic        w_cmd_pop;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcast <= BCAST_RESET;
        end else if (i_cfg_wr_en) begin
            r_bcast <= i_cfg_wr_data;
        end
    end

    pesq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    pesq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bcast     (r_bcast),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = w_res.ev;
    assign o_m_axis_tuser = {w_res.broadcast, w_res.status};

    `PESQ_ASSERT_IMP(a_idle_fields_zero, i_clk, i_rst_n, o_m_axis_tvalid && (w_res.status != ST_SENT), (o_m_axis_tdata == 64'd0) && !w_res.broadcast)
    `PESQ_ASSERT_IMP(a_bcast_only_sent, i_clk, i_rst_n, o_m_axis_tvalid && w_res.broadcast, w_res.status == ST_SENT)
    `PESQ_ASSERT_NXT(a_reset_no_result, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule
